// ----- rtl/tli_pkg.sv -----
`default_nettype none

package tli_pkg;

  localparam int FREQ_W        = 32;
  localparam int SIGMA_W       = 32;
  localparam int ENTRY_IDX_W   = 8;
  localparam int POINTS_W      = 9;
  localparam int BRACKET_W     = 8;
  localparam int REGION_W      = 2;
  localparam int TABLE_POINTS_DEF = 256;
  localparam logic [POINTS_W-1:0] POINTS_RESET = 9'd2;
  localparam int MIN_POINTS    = 2;

  // one quotient bit per step
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam int ENTRY_W       = FREQ_W + SIGMA_W;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [REGION_W-1:0] {
    REGION_BELOW  = 2'd0,
    REGION_ABOVE  = 2'd1,
    REGION_INTERP = 2'd2
  } region_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_CACHE_L,
    ST_CACHE_R,
    ST_BS_ADDR,
    ST_BS_CMP,
    ST_LD_L,
    ST_LD_R,
    ST_PREP,
    ST_MUL,
    ST_DIV_CHK,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/tli_item_if.sv -----
`default_nettype none

interface tli_item_if import tli_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [FREQ_W-1:0]      entry_freq;
  logic [SIGMA_W-1:0]     entry_sigma;
  logic [FREQ_W-1:0]      query_freq;

  modport source (
    output valid, action, entry_index, entry_freq, entry_sigma, query_freq,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, entry_freq, entry_sigma, query_freq,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tli_result_if.sv -----
`default_nettype none

interface tli_result_if import tli_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SIGMA_W-1:0]   sigma_out;
  logic [REGION_W-1:0]  region;
  logic [BRACKET_W-1:0] bracket_index;

  modport source (
    output valid, sigma_out, region, bracket_index,
    input  ready
  );

  modport sink (
    input  valid, sigma_out, region, bracket_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tli_ram.sv -----
`default_nettype none

module tli_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/table_linear_interpolator.sv -----
`default_nettype none

// Table lookup with linear interpolation.
// item_i carries load and query transfers. A load (action = 0) writes one
// (frequency, sigma) point at entry_index in the cycle it is accepted; it
// gives no result and clears the cached bracket. A query (action = 1) gives
// one result transfer on result_o: 0 below the first point, the last sigma
// above the last point, else the interpolated sigma and the bracket's left index.
// cfg_we_i / cfg_wdata_i write points_in_use (clamped to 2..TABLE_POINTS).
// A query checks the first point, then the last, then the cached bracket if it
// lies within the points in use, and bisects the table if that misses. A
// zero-width bracket or a quotient past 32 bits skips the divide. Each probe
// has an issue and a compare state in the registered-read RAM; the slope
// divide runs 32 restoring steps. item_i.ready is high only while the
// sequencer is idle; a new item can be accepted once the previous result
// has moved into the output register.
// A result waits in the output register until result_o takes it; meanwhile
// loads go on and one more query is worked out, then item_i stalls.
// Reset clears the sequencer and the output valid, sets points_in_use to 2
// and the cached bracket to 0; table contents are undefined until loaded.
module table_linear_interpolator import tli_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [POINTS_W-1:0] cfg_wdata_i,
  tli_item_if.sink                 item_i,
  tli_result_if.source             result_o
);

  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam int CNT_W = $clog2(TABLE_POINTS + 1);

  state_e state_q, state_d;

  logic [POINTS_W-1:0] points_q;
  logic [IDX_W-1:0]    cache_q;

  // query context
  logic [FREQ_W-1:0]   q_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    n_clamped;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    br_q;
  logic [IDX_W-1:0]    br_next;

  // bisection window
  logic [IDX_W-1:0]    bs_lo_q, bs_hi_q, bs_mid_q;
  logic [IDX_W:0]      bs_sum;
  logic [IDX_W-1:0]    bs_mid;
  logic                bs_done;

  // bracket endpoints
  logic [FREQ_W-1:0]   fl_q, fr_q;
  logic [SIGMA_W-1:0]  sl_q, sr_q;

  // slope arithmetic
  logic [SIGMA_W-1:0]  ds_q;
  logic [FREQ_W-1:0]   dq_q, dw_q;
  logic                neg_q;
  logic                ovf_q;
  logic [FREQ_W-1:0]   rem_q;
  logic [SIGMA_W-1:0]  quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [FREQ_W:0]     div_trial;
  logic [FREQ_W:0]     div_diff;
  logic                div_ge;
  logic                neg_mix;
  logic [SIGMA_W-1:0]  ds_mag;
  logic [FREQ_W-1:0]   dq_mag, dw_mag;

  // working result
  logic [SIGMA_W-1:0]   res_sigma_q;
  region_e              res_region_q;
  logic [BRACKET_W-1:0] res_bracket_q;
  logic [SIGMA_W-1:0]   final_sigma;

  // output register
  logic                 out_valid_q;
  logic                 out_free;
  logic [SIGMA_W-1:0]   out_sigma_q;
  region_e              out_region_q;
  logic [BRACKET_W-1:0] out_bracket_q;

  // table RAM: {freq, sigma}
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FREQ_W-1:0]  rd_freq;
  logic [SIGMA_W-1:0] rd_sigma;

  logic item_xfer;
  logic load_ok;
  logic cache_fits;

  tli_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(item_i.entry_index)),
    .wdata_i ({item_i.entry_freq, item_i.entry_sigma}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_freq  = ram_rdata[ENTRY_W-1:SIGMA_W];
  assign rd_sigma = ram_rdata[SIGMA_W-1:0];

  assign item_xfer = item_i.valid && item_i.ready;
  assign load_ok   = (32'(item_i.entry_index) < TABLE_POINTS);
  assign ram_we    = item_xfer && (item_i.action == ACT_LOAD) && load_ok;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    if (32'(points_q) > TABLE_POINTS) begin
      n_clamped = CNT_W'(TABLE_POINTS);
    end else if (32'(points_q) < MIN_POINTS) begin
      n_clamped = CNT_W'(MIN_POINTS);
    end else begin
      n_clamped = CNT_W'(points_q);
    end
  end

  assign last_idx   = IDX_W'(n_q - CNT_W'(1));
  assign br_next    = br_q + IDX_W'(1);
  assign cache_fits = (CNT_W'(cache_q) + CNT_W'(1)) < n_q;

  assign bs_sum  = {1'b0, bs_lo_q} + {1'b0, bs_hi_q};
  assign bs_mid  = bs_sum[IDX_W:1];
  assign bs_done = (bs_hi_q - bs_lo_q) <= IDX_W'(1);

  // shared compare/subtract step of the restoring divider
  assign div_trial = {rem_q, quo_q[SIGMA_W-1]};
  assign div_diff  = div_trial - {1'b0, dw_q};
  assign div_ge    = div_trial >= {1'b0, dw_q};

  // magnitudes and sign of the slope terms
  always_comb begin
    neg_mix = 1'b0;
    if (sr_q >= sl_q) begin
      ds_mag = sr_q - sl_q;
    end else begin
      ds_mag  = sl_q - sr_q;
      neg_mix = ~neg_mix;
    end
    if (q_q >= fl_q) begin
      dq_mag = q_q - fl_q;
    end else begin
      dq_mag  = fl_q - q_q;
      neg_mix = ~neg_mix;
    end
    if (fr_q >= fl_q) begin
      dw_mag = fr_q - fl_q;
    end else begin
      dw_mag  = fl_q - fr_q;
      neg_mix = ~neg_mix;
    end
  end

  // apply quotient to the left sigma with saturation
  always_comb begin
    if (neg_q) begin
      if (ovf_q || (quo_q > sl_q)) begin
        final_sigma = '0;
      end else begin
        final_sigma = sl_q - quo_q;
      end
    end else begin
      if (ovf_q || (quo_q > ~sl_q)) begin
        final_sigma = '1;
      end else begin
        final_sigma = sl_q + quo_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_xfer && (item_i.action == ACT_QUERY)) begin
          state_d = ST_CHK_LO;
        end
      end
      ST_CHK_LO: begin
        state_d = (q_q < rd_freq) ? ST_OUT : ST_CHK_HI;
      end
      ST_CHK_HI: begin
        if (q_q > rd_freq) begin
          state_d = ST_OUT;
        end else if (cache_fits) begin
          state_d = ST_CACHE_L;
        end else begin
          state_d = ST_BS_ADDR;
        end
      end
      ST_CACHE_L: begin
        state_d = (q_q >= rd_freq) ? ST_CACHE_R : ST_BS_ADDR;
      end
      ST_CACHE_R: begin
        state_d = (q_q <= rd_freq) ? ST_PREP : ST_BS_ADDR;
      end
      ST_BS_ADDR: begin
        state_d = bs_done ? ST_LD_L : ST_BS_CMP;
      end
      ST_BS_CMP: begin
        state_d = ST_BS_ADDR;
      end
      ST_LD_L: begin
        state_d = ST_LD_R;
      end
      ST_LD_R: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = (fr_q == fl_q) ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        // high half already >= divisor: quotient exceeds 32 bits, saturate
        state_d = (rem_q >= dw_q) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_i.ready = 1'b0;
    ram_raddr    = '0;
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
      end
      ST_CHK_LO: begin
        ram_raddr = last_idx;
      end
      ST_CHK_HI: begin
        ram_raddr = cache_q;
      end
      ST_CACHE_L, ST_LD_L: begin
        ram_raddr = br_next;
      end
      ST_BS_ADDR: begin
        ram_raddr = bs_done ? bs_lo_q : bs_mid;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      points_q    <= POINTS_RESET;
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        points_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        cache_q <= '0;
      end else if ((state_q == ST_BS_ADDR) && bs_done) begin
        cache_q <= bs_lo_q;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        q_q <= item_i.query_freq;
        n_q <= n_clamped;
      end
      ST_CHK_LO: begin
        res_sigma_q   <= '0;
        res_region_q  <= REGION_BELOW;
        res_bracket_q <= '0;
      end
      ST_CHK_HI: begin
        res_sigma_q   <= rd_sigma;
        res_region_q  <= REGION_ABOVE;
        res_bracket_q <= '0;
        br_q          <= cache_q;
        bs_lo_q       <= '0;
        bs_hi_q       <= last_idx;
      end
      ST_CACHE_L: begin
        fl_q    <= rd_freq;
        sl_q    <= rd_sigma;
        bs_lo_q <= '0;
        bs_hi_q <= last_idx;
      end
      ST_CACHE_R: begin
        fr_q    <= rd_freq;
        sr_q    <= rd_sigma;
        bs_lo_q <= '0;
        bs_hi_q <= last_idx;
      end
      ST_BS_ADDR: begin
        bs_mid_q <= bs_mid;
        br_q     <= bs_lo_q;
      end
      ST_BS_CMP: begin
        if (rd_freq <= q_q) begin
          bs_lo_q <= bs_mid_q;
        end else begin
          bs_hi_q <= bs_mid_q;
        end
      end
      ST_LD_L: begin
        fl_q <= rd_freq;
        sl_q <= rd_sigma;
      end
      ST_LD_R: begin
        fr_q <= rd_freq;
        sr_q <= rd_sigma;
      end
      ST_PREP: begin
        ds_q          <= ds_mag;
        dq_q          <= dq_mag;
        dw_q          <= dw_mag;
        neg_q         <= neg_mix;
        res_sigma_q   <= sl_q;
        res_region_q  <= REGION_INTERP;
        res_bracket_q <= BRACKET_W'(br_q);
      end
      ST_MUL: begin
        {rem_q, quo_q} <= ds_q * dq_q;
      end
      ST_DIV_CHK: begin
        ovf_q     <= (rem_q >= dw_q);
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q     <= div_ge ? div_diff[FREQ_W-1:0] : div_trial[FREQ_W-1:0];
        quo_q     <= {quo_q[SIGMA_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      ST_FINISH: begin
        res_sigma_q <= final_sigma;
      end
      ST_OUT: begin
        if (out_free) begin
          out_sigma_q   <= res_sigma_q;
          out_region_q  <= res_region_q;
          out_bracket_q <= res_bracket_q;
        end
      end
      default: begin
        res_sigma_q <= res_sigma_q;
      end
    endcase
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.sigma_out     = out_sigma_q;
  assign result_o.region        = out_region_q;
  assign result_o.bracket_index = out_bracket_q;

endmodule

`default_nettype wire
